[design/cialu_pkg.sv]
// Shared constants and operation codes for the complex integer ALU.
`default_nettype none
package cialu_pkg;
  localparam int FIELD_W = 32;
  localparam int PART_WIDTH_DEF = 32;
  localparam int ACT_W = 3;

  localparam logic [ACT_W-1:0] ACT_ADD = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SUB = 3'd1;
  localparam logic [ACT_W-1:0] ACT_MUL = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DIV = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CMP = 3'd4;
endpackage
`default_nettype wire

[design/cialu_if.sv]
// Valid/ready channels for operand words and result words.
`default_nettype none
interface cialu_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [cialu_pkg::ACT_W-1:0]           action;
  logic signed [cialu_pkg::FIELD_W-1:0]  a_re;
  logic signed [cialu_pkg::FIELD_W-1:0]  a_im;
  logic signed [cialu_pkg::FIELD_W-1:0]  b_re;
  logic signed [cialu_pkg::FIELD_W-1:0]  b_im;
  modport source (output valid, action, a_re, a_im, b_re, b_im, input ready);
  modport sink (input valid, action, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cialu_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cialu_pkg::FIELD_W-1:0]  result_re;
  logic signed [cialu_pkg::FIELD_W-1:0]  result_im;
  logic                                  is_equal;
  logic                                  divide_by_zero;
  modport source (output valid, result_re, result_im, is_equal, divide_by_zero,
                  input ready);
  modport sink (input valid, result_re, result_im, is_equal, divide_by_zero,
                output ready);
endinterface
`default_nettype wire

[design/complex_integer_alu_top.sv]
// Complex integer ALU: add, subtract, multiply, divide and compare, pipelined.
//
// Usage: operand words enter on in_word (valid/ready), one result word leaves
// on out_word for each operand word, in order. Each part uses the low
// PART_WIDTH bits of its field as two's complement; results are wrapped to
// PART_WIDTH bits and sign-extended to 32.
// The restoring divider retires one quotient bit per stage.
// Throughput: one word per cycle while the output is not stalled; every
// operation goes through all stages.
// Stages: input register, multipliers, sums and magnitudes, divider stages,
// output register.
// Reset: all stage valid bits clear; the pipeline is empty and ready.
// Stall: while out_word.valid is high and out_word.ready is low the whole
// pipeline holds; bubbles are not squeezed out. in_word.ready follows
// out_word.ready combinationally when the output register is full.
`default_nettype none
module complex_integer_alu_top #(
  parameter int PART_WIDTH = cialu_pkg::PART_WIDTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  cialu_in_if.sink      in_word,
  cialu_out_if.source   out_word
);
  localparam int W  = PART_WIDTH;
  localparam int W2 = 2 * PART_WIDTH;
  localparam int ND = 2 * PART_WIDTH;

  typedef struct packed {
    logic         is_div;
    logic         neg_re;
    logic         neg_im;
    logic         eq;
    logic         dz;
    logic [W-1:0] alt_re;
    logic [W-1:0] alt_im;
  } side_t;

  logic adv;
  assign adv = !out_word.valid || out_word.ready;
  assign in_word.ready = adv;

  // Stage 1: operand register
  logic                        s1_v_r;
  logic [cialu_pkg::ACT_W-1:0] s1_act_r;
  logic signed [W-1:0]         s1_ar_r, s1_ai_r, s1_br_r, s1_bi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_word.valid;
    end
    if (adv) begin
      s1_act_r <= in_word.action;
      s1_ar_r  <= in_word.a_re[W-1:0];
      s1_ai_r  <= in_word.a_im[W-1:0];
      s1_br_r  <= in_word.b_re[W-1:0];
      s1_bi_r  <= in_word.b_im[W-1:0];
    end
  end

  // Stage 2: products, add/sub, compare
  logic                        s2_v_r;
  logic [cialu_pkg::ACT_W-1:0] s2_act_r;
  logic signed [W2-1:0]        s2_rr_r, s2_ii_r, s2_ri_r, s2_ir_r, s2_bbr_r, s2_bbi_r;
  logic [W-1:0]                s2_add_re_r, s2_add_im_r, s2_sub_re_r, s2_sub_im_r;
  logic                        s2_eq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
    if (adv) begin
      s2_act_r    <= s1_act_r;
      s2_rr_r     <= s1_ar_r * s1_br_r;
      s2_ii_r     <= s1_ai_r * s1_bi_r;
      s2_ri_r     <= s1_ar_r * s1_bi_r;
      s2_ir_r     <= s1_ai_r * s1_br_r;
      s2_bbr_r    <= s1_br_r * s1_br_r;
      s2_bbi_r    <= s1_bi_r * s1_bi_r;
      s2_add_re_r <= W'(s1_ar_r + s1_br_r);
      s2_add_im_r <= W'(s1_ai_r + s1_bi_r);
      s2_sub_re_r <= W'(s1_ar_r - s1_br_r);
      s2_sub_im_r <= W'(s1_ai_r - s1_bi_r);
      s2_eq_r     <= (s1_ar_r == s1_br_r) && (s1_ai_r == s1_bi_r);
    end
  end

  // Stage 3: numerators, divisor, magnitudes, side results
  logic signed [W2:0] nr, ni;
  logic [W2-1:0]      den;
  side_t              s3_side;

  always_comb begin
    nr  = (W2+1)'(s2_rr_r) + (W2+1)'(s2_ii_r);
    ni  = (W2+1)'(s2_ir_r) - (W2+1)'(s2_ri_r);
    den = W2'(s2_bbr_r) + W2'(s2_bbi_r);
    s3_side.is_div = (s2_act_r == cialu_pkg::ACT_DIV);
    s3_side.neg_re = nr[W2];
    s3_side.neg_im = ni[W2];
    s3_side.eq     = (s2_act_r == cialu_pkg::ACT_CMP) && s2_eq_r;
    s3_side.dz     = (s2_act_r == cialu_pkg::ACT_DIV) && (den == '0);
    s3_side.alt_re = '0;
    s3_side.alt_im = '0;
    unique case (s2_act_r)
      cialu_pkg::ACT_ADD: begin
        s3_side.alt_re = s2_add_re_r;
        s3_side.alt_im = s2_add_im_r;
      end
      cialu_pkg::ACT_SUB: begin
        s3_side.alt_re = s2_sub_re_r;
        s3_side.alt_im = s2_sub_im_r;
      end
      cialu_pkg::ACT_MUL: begin
        s3_side.alt_re = W'(s2_rr_r - s2_ii_r);
        s3_side.alt_im = W'(s2_ri_r + s2_ir_r);
      end
      default: ;
    endcase
  end

  // Divider pipeline: index 0 is fed from stage 3, index ND is the finished quotient
  logic          dv_v_r   [0:ND];
  side_t         dv_side_r[0:ND];
  logic [W2-1:0] dv_den_r [0:ND];
  logic [W2-1:0] dv_nre_r [0:ND];  // remaining dividend bits, then quotient bits
  logic [W2-1:0] dv_nim_r [0:ND];
  logic [W2:0]   dv_rre_r [0:ND];
  logic [W2:0]   dv_rim_r [0:ND];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= s2_v_r;
    end
    if (adv) begin
      dv_side_r[0] <= s3_side;
      dv_den_r[0]  <= den;
      dv_nre_r[0]  <= nr[W2] ? W2'(-nr) : W2'(nr);
      dv_nim_r[0]  <= ni[W2] ? W2'(-ni) : W2'(ni);
      dv_rre_r[0]  <= '0;
      dv_rim_r[0]  <= '0;
    end
  end

  for (genvar k = 0; k < ND; k++) begin : g_div
    logic [W2:0] sh_re, sh_im;
    logic        q_re, q_im;
    always_comb begin
      sh_re = {dv_rre_r[k][W2-1:0], dv_nre_r[k][W2-1]};
      sh_im = {dv_rim_r[k][W2-1:0], dv_nim_r[k][W2-1]};
      q_re  = (sh_re >= {1'b0, dv_den_r[k]});
      q_im  = (sh_im >= {1'b0, dv_den_r[k]});
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
      if (adv) begin
        dv_side_r[k+1] <= dv_side_r[k];
        dv_den_r[k+1]  <= dv_den_r[k];
        dv_nre_r[k+1]  <= {dv_nre_r[k][W2-2:0], q_re};
        dv_nim_r[k+1]  <= {dv_nim_r[k][W2-2:0], q_im};
        dv_rre_r[k+1]  <= q_re ? sh_re - {1'b0, dv_den_r[k]} : sh_re;
        dv_rim_r[k+1]  <= q_im ? sh_im - {1'b0, dv_den_r[k]} : sh_im;
      end
    end
  end

  // Output stage: sign the quotient, select, sign-extend
  side_t        fin;
  logic [W-1:0] q_re_w, q_im_w, res_re, res_im;

  always_comb begin
    fin    = dv_side_r[ND];
    q_re_w = fin.neg_re ? W'(-dv_nre_r[ND]) : W'(dv_nre_r[ND]);
    q_im_w = fin.neg_im ? W'(-dv_nim_r[ND]) : W'(dv_nim_r[ND]);
    if (fin.is_div) begin
      res_re = fin.dz ? '0 : q_re_w;
      res_im = fin.dz ? '0 : q_im_w;
    end else begin
      res_re = fin.alt_re;
      res_im = fin.alt_im;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_word.valid <= 1'b0;
    end else if (adv) begin
      out_word.valid <= dv_v_r[ND];
    end
    if (adv) begin
      out_word.result_re      <= cialu_pkg::FIELD_W'(signed'(res_re));
      out_word.result_im      <= cialu_pkg::FIELD_W'(signed'(res_im));
      out_word.is_equal       <= fin.eq;
      out_word.divide_by_zero <= fin.dz;
    end
  end
endmodule
`default_nettype wire

[design/cialu_chk.sv]
// Port-level checker for the complex integer ALU, bound to the top level.
`default_nettype none
module cialu_chk (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic signed [cialu_pkg::FIELD_W-1:0] result_re,
  input wire logic signed [cialu_pkg::FIELD_W-1:0] result_im,
  input wire logic                                 is_equal,
  input wire logic                                 divide_by_zero
);
  // a stalled word stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_re) && $stable(result_im))
    else $error("stalled result word changed");

  // flags come from different operations
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(is_equal && divide_by_zero))
    else $error("both flags set");

  // compare result carries zero parts
  a_eq_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_equal |-> result_re == '0 && result_im == '0)
    else $error("compare result with nonzero parts");

  // zero divisor gives zero parts
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && divide_by_zero |-> result_re == '0 && result_im == '0)
    else $error("divide by zero with nonzero parts");
endmodule

bind complex_integer_alu_top cialu_chk u_cialu_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_word.valid),
  .out_ready      (out_word.ready),
  .result_re      (out_word.result_re),
  .result_im      (out_word.result_im),
  .is_equal       (out_word.is_equal),
  .divide_by_zero (out_word.divide_by_zero)
);
`default_nettype wire

[bench/cialu_checker.sv]
// Result checker for the complex integer ALU: predicts each result word and compares.
`timescale 1ns / 100ps
`default_nettype none
module cialu_checker #(
  parameter int PART_WIDTH = cialu_pkg::PART_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cialu_in_if.sink  in_word,
  cialu_out_if.sink out_word,
  output int        fail_count,
  output int        pending_count
);
  typedef struct packed {
    logic signed [cialu_pkg::FIELD_W-1:0] re;
    logic signed [cialu_pkg::FIELD_W-1:0] im;
    logic                                 eq;
    logic                                 dz;
  } alu_result_t;

  alu_result_t expected_results[$];

  assign pending_count = expected_results.size();

  // Low PART_WIDTH bits read as two's complement.
  function automatic logic signed [127:0] part_val(logic [cialu_pkg::FIELD_W-1:0] x);
    logic signed [127:0] v;
    v = x << (128 - PART_WIDTH);
    return v >>> (128 - PART_WIDTH);
  endfunction

  // Wrap to PART_WIDTH bits, sign-extend to the field.
  function automatic logic [cialu_pkg::FIELD_W-1:0] part_wrap(logic signed [127:0] v);
    return cialu_pkg::FIELD_W'(part_val(v[cialu_pkg::FIELD_W-1:0]));
  endfunction

  function automatic alu_result_t complex_op(logic [cialu_pkg::ACT_W-1:0] act,
      logic [cialu_pkg::FIELD_W-1:0] ar_f, logic [cialu_pkg::FIELD_W-1:0] ai_f,
      logic [cialu_pkg::FIELD_W-1:0] br_f, logic [cialu_pkg::FIELD_W-1:0] bi_f);
    alu_result_t r;
    logic signed [127:0] ar, ai, br, bi, re, im, d, nr, ni;
    ar = part_val(ar_f); ai = part_val(ai_f);
    br = part_val(br_f); bi = part_val(bi_f);
    re = 0; im = 0;
    r = '0;
    case (act)
      cialu_pkg::ACT_ADD: begin re = ar + br; im = ai + bi; end
      cialu_pkg::ACT_SUB: begin re = ar - br; im = ai - bi; end
      cialu_pkg::ACT_MUL: begin re = ar * br - ai * bi; im = ar * bi + ai * br; end
      cialu_pkg::ACT_DIV: begin
        d = br * br + bi * bi;
        if (d == 0) begin
          r.dz = 1'b1;
        end else begin
          // signed division truncates toward zero
          nr = ar * br + ai * bi;
          ni = ai * br - ar * bi;
          re = nr / d;
          im = ni / d;
        end
      end
      cialu_pkg::ACT_CMP: r.eq = (ar == br) && (ai == bi);
      default: ;
    endcase
    r.re = part_wrap(re);
    r.im = part_wrap(im);
    return r;
  endfunction

  // Predict on accepted operand words, compare accepted result words.
  always @(posedge clk) begin
    alu_result_t got, want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_word.valid && in_word.ready)
        expected_results.push_back(complex_op(in_word.action, in_word.a_re,
                                              in_word.a_im, in_word.b_re, in_word.b_im));
      if (out_word.valid && out_word.ready) begin
        got = '{out_word.result_re, out_word.result_im,
                out_word.is_equal, out_word.divide_by_zero};
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("result word with nothing expected: %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("mismatch: expected re=%0d im=%0d eq=%b dz=%b got re=%0d im=%0d eq=%b dz=%b",
                       want.re, want.im, want.eq, want.dz,
                       got.re, got.im, got.eq, got.dz);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

[bench/complex_integer_alu_top_tb.sv]
// Testbench top for the complex integer ALU: stimulus, idling and verdict.
`timescale 1ns / 100ps
`default_nettype none
module complex_integer_alu_top_tb;
  localparam int RANDOM_WORDS = 1130;
  localparam int LATENCY = 2 * cialu_pkg::PART_WIDTH_DEF + 4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending_count;
  int   words_sent = 0;
  logic quiet_phase = 1'b0;

  cialu_in_if  in_word();
  cialu_out_if out_word();

  complex_integer_alu_top dut (.clk(clk), .rst_n(rst_n),
                               .in_word(in_word), .out_word(out_word));
  cialu_checker chk (.clk(clk), .rst_n(rst_n), .in_word(in_word),
                     .out_word(out_word), .fail_count(fail_count),
                     .pending_count(pending_count));

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Random operand part, biased toward extremes and small values.
  function automatic logic [31:0] pick_part();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return '0;
      4: return $urandom_range(0, 20) - 10;
      5: return $urandom_range(0, 65535) - 32768;
      default: return $urandom;
    endcase
  endfunction

  // Present one word and hold it until accepted.
  task automatic send_word(logic [cialu_pkg::ACT_W-1:0] act, logic [31:0] ar,
                           logic [31:0] ai, logic [31:0] br, logic [31:0] bi);
    in_word.valid  <= 1'b1;
    in_word.action <= act;
    in_word.a_re <= ar; in_word.a_im <= ai;
    in_word.b_re <= br; in_word.b_im <= bi;
    @(posedge clk);
    while (!in_word.ready) @(posedge clk);
    words_sent++;
    // sender gap burst
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_word.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Receiver stalls in bursts; none near the end.
  always @(posedge clk) begin
    if (!rst_n || quiet_phase) out_word.ready <= 1'b1;
    else if ($urandom_range(0, 5) == 0) begin
      out_word.ready <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
      out_word.ready <= 1'b1;
    end else out_word.ready <= 1'b1;
  end

  initial begin
    logic [cialu_pkg::ACT_W-1:0] act;
    logic [31:0] ar, ai;
    in_word.valid = 1'b0;
    in_word.action = cialu_pkg::ACT_ADD;
    in_word.a_re = '0; in_word.a_im = '0;
    in_word.b_re = '0; in_word.b_im = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, every operation, zero divisor, equal/unequal, unknown codes
    send_word(cialu_pkg::ACT_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff);
    send_word(cialu_pkg::ACT_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff);
    send_word(cialu_pkg::ACT_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_word(cialu_pkg::ACT_MUL, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_word(cialu_pkg::ACT_MUL, 3, 4, 5, 32'hffff_fffe);
    send_word(cialu_pkg::ACT_DIV, 10, 5, 0, 0);
    send_word(cialu_pkg::ACT_DIV, 7, 32'hffff_fff9, 2, 0);
    send_word(cialu_pkg::ACT_DIV, 32'hffff_fff9, 7, 0, 2);
    send_word(cialu_pkg::ACT_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_word(cialu_pkg::ACT_DIV, 32'h7fff_ffff, 32'h8000_0000, 1, 1);
    send_word(cialu_pkg::ACT_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 0);
    send_word(cialu_pkg::ACT_DIV, 5, 5, 32'h7fff_ffff, 32'h8000_0000);
    send_word(cialu_pkg::ACT_CMP, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_word(cialu_pkg::ACT_CMP, 1, 2, 1, 3);
    send_word(cialu_pkg::ACT_CMP, 1, 2, 0, 2);
    send_word(3'd5, 1, 2, 3, 4);
    send_word(3'd6, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_word(3'd7, 32'h8000_0000, 0, 0, 0);
    send_word(cialu_pkg::ACT_ADD, 0, 0, 0, 0);
    // random words
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS - 150) quiet_phase = 1'b1;
      act = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                         : 3'($urandom_range(0, 4));
      ar = pick_part();
      ai = pick_part();
      if (act == cialu_pkg::ACT_CMP && $urandom_range(0, 1))
        send_word(act, ar, ai, ($urandom_range(0, 1) ? ar : pick_part()), ai);
      else if (act == cialu_pkg::ACT_DIV && $urandom_range(0, 9) == 0)
        send_word(act, ar, ai, 0, 0);
      else
        send_word(act, ar, ai, pick_part(), pick_part());
    end
    in_word.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire
